// ----- design/text_line_number_and_visualize_filter_defines.svh -----
// assertion macros for the text line numbering and visualizing filter
`ifndef TEXT_LINE_NUMBER_AND_VISUALIZE_FILTER_DEFINES_SVH
`define TEXT_LINE_NUMBER_AND_VISUALIZE_FILTER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TLNV_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlnv same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TLNV_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlnv next-cycle check failed");

`endif

// ----- design/tlnv_pkg.sv -----
// shared types and constants of the text line numbering and visualizing filter
`default_nettype none

package tlnv_pkg;

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 8;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_NUMBER_MODE      = 8'd0,
    REG_SQUEEZE_EMPTY    = 8'd1,
    REG_SHOW_NONPRINTING = 8'd2,
    REG_SHOW_LINE_ENDS   = 8'd3,
    REG_SHOW_TABS        = 8'd4
  } cfg_reg_t;

  localparam logic [1:0] NUM_NONE  = 2'd0;
  localparam logic [1:0] NUM_ALL   = 2'd1;

  localparam logic [7:0] CH_NL      = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_ZERO    = 8'd48;
  localparam logic [7:0] CH_M       = 8'd77;
  localparam logic [7:0] CH_DASH    = 8'd45;
  localparam logic [7:0] CH_CARET   = 8'd94;
  localparam logic [7:0] CH_DOLLAR  = 8'd36;
  localparam logic [7:0] CH_QMARK   = 8'd63;
  localparam logic [7:0] CH_I       = 8'd73;
  localparam logic [7:0] CH_DEL     = 8'd127;
  localparam logic [7:0] CH_CTRL_TOP = 8'd32;
  localparam logic [7:0] CTRL_SHIFT = 8'd64;
  localparam logic [3:0] BCD_NINE   = 4'd9;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       first_of_file;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_word_t;

endpackage

`default_nettype wire

// ----- design/text_line_number_and_visualize_filter.sv -----
// top level: line numbering, blank squeezing and nonprinting display filter
// an accepted word loads the working stage; its results go to the output register
// throughput: one result word per cycle unless the output stalls; a word holds input
// until its last result; unstalled, a single-result word (plain byte) enters every cycle
// rst (synchronous) clears registers to off, history to newline/zero, count to zero
`default_nettype none

module text_line_number_and_visualize_filter #(
  parameter int COUNT_DIGITS = 6
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire tlnv_pkg::in_word_t             in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      tlnv_pkg::out_word_t            out_data,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [tlnv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [tlnv_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tlnv_pkg::*;

  `include "text_line_number_and_visualize_filter_defines.svh"

  // slot order of the results of one word: digits, tab, 'M', '-', caret, '$', char
  localparam int CNT_W     = 4 * COUNT_DIGITS;
  localparam int SLOT_N    = COUNT_DIGITS + 6;
  localparam int SLOT_W    = $clog2(SLOT_N);
  localparam int SLOT_TAB  = COUNT_DIGITS;
  localparam int SLOT_M    = COUNT_DIGITS + 1;
  localparam int SLOT_DASH = COUNT_DIGITS + 2;
  localparam int SLOT_CRT  = COUNT_DIGITS + 3;
  localparam int SLOT_DOL  = COUNT_DIGITS + 4;
  localparam int SLOT_CHR  = COUNT_DIGITS + 5;

  // configuration registers
  logic [1:0] number_mode;
  logic       squeeze_empty;
  logic       show_nonprinting;
  logic       show_line_ends;
  logic       show_tabs;

  // byte history and line count
  logic [7:0]       older_byte;
  logic [7:0]       newest_byte;
  logic [CNT_W-1:0] line_count;

  // working stage: pending result slots and the final char of the word
  logic [SLOT_N-1:0] slot_mask;
  logic [7:0]        cur_char;

  logic in_fire;
  logic cur_valid;
  logic cur_emit;
  logic cur_last;

  // ---------------------------------------------------------------
  // configuration port, always ready; values masked to their widths
  // ---------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_mode      <= '0;
      squeeze_empty    <= 1'b0;
      show_nonprinting <= 1'b0;
      show_line_ends   <= 1'b0;
      show_tabs        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_NUMBER_MODE:      number_mode      <= cfg_data[1:0];
        REG_SQUEEZE_EMPTY:    squeeze_empty    <= cfg_data[0];
        REG_SHOW_NONPRINTING: show_nonprinting <= cfg_data[0];
        REG_SHOW_LINE_ENDS:   show_line_ends   <= cfg_data[0];
        REG_SHOW_TABS:        show_tabs        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // decode of an incoming word against the history it sees
  // ---------------------------------------------------------------
  logic [7:0]       older_eff;
  logic [7:0]       newest_eff;
  logic [CNT_W-1:0] count_eff;
  logic [CNT_W-1:0] count_inc;
  logic             squeeze_hit;
  logic             do_num;
  logic             do_m;
  logic             do_caret;
  logic             do_dollar;
  logic [7:0]       char_low;
  logic [7:0]       char_vis;
  logic [7:0]       char_out;
  logic [SLOT_N-1:0] mask_load;

  always_comb begin
    // first-of-file word starts from the reset history
    older_eff  = in_data.first_of_file ? 8'd0  : older_byte;
    newest_eff = in_data.first_of_file ? CH_NL : newest_byte;
    count_eff  = in_data.first_of_file ? '0    : line_count;
  end

  // saturating bcd increment; a digit rolls when every lower digit is nine
  always_comb begin
    logic carry;
    logic full;
    carry     = 1'b1;
    full      = 1'b1;
    count_inc = count_eff;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (count_eff[4*i +: 4] != BCD_NINE) begin
        full = 1'b0;
      end
    end
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (carry) begin
        if (count_eff[4*i +: 4] >= BCD_NINE) begin
          count_inc[4*i +: 4] = 4'd0;
        end else begin
          count_inc[4*i +: 4] = count_eff[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (full) begin
      count_inc = count_eff;
    end
  end

  always_comb begin
    squeeze_hit = squeeze_empty && (in_data.in_byte == CH_NL) &&
                  (older_eff == CH_NL) && (newest_eff == CH_NL);
    // blank-line test looks at the raw byte
    do_num = (newest_eff == CH_NL) &&
             ((number_mode == NUM_ALL) || (number_mode[1] && (in_data.in_byte != CH_NL)));

    // high bytes: M- and strip bit 7
    do_m     = show_nonprinting && in_data.in_byte[7];
    char_low = do_m ? {1'b0, in_data.in_byte[6:0]} : in_data.in_byte;

    // control bytes and delete in caret notation
    do_caret = 1'b0;
    char_vis = char_low;
    if (show_nonprinting && (char_low < CH_CTRL_TOP) &&
        (char_low != CH_NL) && (char_low != CH_TAB)) begin
      do_caret = 1'b1;
      char_vis = char_low + CTRL_SHIFT;
    end else if (show_nonprinting && (char_low == CH_DEL)) begin
      do_caret = 1'b1;
      char_vis = CH_QMARK;
    end

    do_dollar = show_line_ends && (char_vis == CH_NL);

    // tab shown as ^I shares the caret slot (never both on one word)
    char_out = char_vis;
    if (show_tabs && (char_vis == CH_TAB)) begin
      do_caret = 1'b1;
      char_out = CH_I;
    end

    mask_load = '0;
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      mask_load[k] = do_num;
    end
    mask_load[SLOT_TAB]  = do_num;
    mask_load[SLOT_M]    = do_m;
    mask_load[SLOT_DASH] = do_m;
    mask_load[SLOT_CRT]  = do_caret;
    mask_load[SLOT_DOL]  = do_dollar;
    mask_load[SLOT_CHR]  = 1'b1;
  end

  // ---------------------------------------------------------------
  // handshakes: a new word enters when none is pending or as the working word hands over its last slot
  // ---------------------------------------------------------------
  assign cur_valid = |slot_mask;
  assign cur_emit  = cur_valid && (!out_valid || out_ready);
  assign cur_last  = ((slot_mask & (slot_mask - SLOT_N'(1))) == '0);
  assign in_ready  = !cur_valid || (cur_emit && cur_last);
  assign in_fire   = in_valid && in_ready;

  // history and count move at accept; while a word is being emitted the
  // count register already holds the value it prints
  always_ff @(posedge clk) begin
    if (rst) begin
      older_byte  <= 8'd0;
      newest_byte <= CH_NL;
      line_count  <= '0;
    end else if (in_fire) begin
      older_byte  <= newest_eff;
      if (squeeze_hit) begin
        newest_byte <= in_data.in_byte;
        line_count  <= count_eff;
      end else begin
        newest_byte <= char_out;
        line_count  <= do_num ? count_inc : count_eff;
      end
    end
  end

  logic [SLOT_N-1:0] slot_mask_next;

  always_comb begin
    slot_mask_next = slot_mask;
    if (cur_emit) begin
      // drop the slot just sent
      slot_mask_next = slot_mask & (slot_mask - SLOT_N'(1));
    end
    if (in_fire) begin
      slot_mask_next = squeeze_hit ? '0 : mask_load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_mask <= '0;
    end else begin
      slot_mask <= slot_mask_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_char <= char_out;
    end
  end

  // ---------------------------------------------------------------
  // slot select and byte for each slot
  // ---------------------------------------------------------------
  logic [SLOT_W-1:0] sel;
  logic [7:0]        slot_char [SLOT_N];

  // lowest pending slot goes first
  always_comb begin
    sel = '0;
    for (int k = SLOT_N - 1; k >= 0; k--) begin
      if (slot_mask[k]) begin
        sel = SLOT_W'(k);
      end
    end
  end

  always_comb begin
    logic lead;
    lead = 1'b1;
    for (int k = 0; k < SLOT_N; k++) begin
      slot_char[k] = cur_char;
    end
    // digits, most significant first; leading zeros blank except the last
    for (int k = 0; k < COUNT_DIGITS; k++) begin
      if ((line_count[4*(COUNT_DIGITS-1-k) +: 4] != 4'd0) || (k == COUNT_DIGITS - 1)) begin
        lead = 1'b0;
      end
      slot_char[k] = lead ? CH_SPACE : (CH_ZERO + {4'd0, line_count[4*(COUNT_DIGITS-1-k) +: 4]});
    end
    slot_char[SLOT_TAB]  = CH_TAB;
    slot_char[SLOT_M]    = CH_M;
    slot_char[SLOT_DASH] = CH_DASH;
    slot_char[SLOT_CRT]  = CH_CARET;
    slot_char[SLOT_DOL]  = CH_DOLLAR;
    slot_char[SLOT_CHR]  = cur_char;
  end

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cur_emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cur_emit) begin
      out_data.out_byte    <= slot_char[sel];
      out_data.last_of_run <= cur_last;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  logic count_full;

  always_comb begin
    count_full = 1'b1;
    for (int i = 0; i < COUNT_DIGITS; i++) begin
      if (line_count[4*i +: 4] != BCD_NINE) begin
        count_full = 1'b0;
      end
    end
  end

  // input only opens over a busy working word when its last slot leaves
  `TLNV_ASSERT_SAME(a_ready_on_last, in_ready && cur_valid, cur_emit && cur_last)
  // a squeezed newline leaves nothing to emit
  `TLNV_ASSERT_NEXT(a_squeeze_empty, in_fire && squeeze_hit, !cur_valid)
  // saturated count only leaves all nines through a new file
  `TLNV_ASSERT_NEXT(a_count_sat, count_full && !(in_fire && in_data.first_of_file), count_full)

endmodule

`default_nettype wire
